// ===== hdl/rrva_pkg.sv =====
`default_nettype none

package rrva_pkg;

   // fixed field widths
   localparam int STAMP_W    = 32;
   localparam int SID_W      = 5;
   localparam int NEXT_W     = 3;
   localparam int VNUM_W     = 3;
   localparam int POOL_W     = 4;
   localparam int MASK_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOLED_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_VOICES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION    = 2'd2;

   localparam logic [POOL_W-1:0] POOL_VOICES_RESET = 4'd8;

   // request payload
   typedef struct packed {
      logic [SID_W-1:0]   sound_id;
      logic [STAMP_W-1:0] now_ms;
   } req_type;

   // response payload
   typedef struct packed {
      logic              direct_play;
      logic              voice_granted;
      logic [VNUM_W-1:0] voice_number;
   } rsp_type;

   // voice memory write control
   typedef struct packed {
      logic               en;
      logic               next_we;
      logic [NEXT_W-1:0]  next;
      logic [STAMP_W-1:0] stamp;
   } wr_type;

endpackage

`default_nettype wire

// ===== hdl/rrva_voice_mem.sv =====
`default_nettype none

module rrva_voice_mem
   import rrva_pkg::*;
#(
   parameter int NUM_SOUNDS = 32,
   parameter int MAX_VOICES = 8,
   localparam int ADDR_W = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 rd_en,
   input  wire logic [ADDR_W-1:0]                    rd_addr,
   output logic      [MAX_VOICES-1:0][STAMP_W-1:0]   rd_times,
   output logic      [NEXT_W-1:0]                    rd_next,
   input  wire wr_type                               wr,
   input  wire logic [ADDR_W-1:0]                    wr_addr,
   input  wire logic [MAX_VOICES-1:0]                wr_lanes
);

   localparam int TIMES_W = MAX_VOICES * STAMP_W;
   localparam int ROW_W = TIMES_W + NEXT_W;

   // one row per sound: saved next index above the voice start times
   logic [ROW_W-1:0] row_mem [NUM_SOUNDS];
   logic [ROW_W-1:0] rd_row_ff;

   // lane-masked write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int v = 0; v < MAX_VOICES; v++) begin
            if (wr_lanes[v]) begin
               row_mem[wr_addr][v*STAMP_W +: STAMP_W] <= wr.stamp;
            end
         end
         if (wr.next_we) begin
            row_mem[wr_addr][ROW_W-1 -: NEXT_W] <= wr.next;
         end
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   assign rd_times = rd_row_ff[TIMES_W-1:0];
   assign rd_next  = rd_row_ff[ROW_W-1 -: NEXT_W];

endmodule

`default_nettype wire

// ===== hdl/rrva_scan.sv =====
`default_nettype none

module rrva_scan
   import rrva_pkg::*;
#(
   parameter int MAX_VOICES = 8,
   localparam int CNT_W  = $clog2(MAX_VOICES + 1),
   localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               load,
   input  wire logic [MAX_VOICES-1:0][STAMP_W-1:0] times,
   input  wire logic [NEXT_W-1:0]                  next_raw,
   input  wire logic [STAMP_W-1:0]                 now,
   input  wire logic [STAMP_W-1:0]                 duration,
   input  wire logic [CNT_W-1:0]                   n,
   output logic                                    found,
   output logic      [VIDX_W-1:0]                  pick
);

   localparam int MOD_W  = (CNT_W > NEXT_W) ? CNT_W : NEXT_W;
   localparam int MOD_STEPS = (1 << NEXT_W) - 1;

   logic [MAX_VOICES-1:0] free_in;
   logic [MAX_VOICES-1:0] free_ff;
   logic [VIDX_W-1:0]     start_in;
   logic [VIDX_W-1:0]     start_ff;
   logic [MOD_W-1:0]      rem;
   logic [MOD_W-1:0]      n_ext;
   logic [MAX_VOICES-1:0] upper;
   logic [VIDX_W-1:0]     pick_upper;
   logic [VIDX_W-1:0]     pick_any;

   // per-voice free test: inside the pool, and never started or wrapped elapsed time reached duration
   always_comb begin
      for (int v = 0; v < MAX_VOICES; v++) begin
         free_in[v] = (v < int'(n)) &&
                      ((times[v] == '0) || ((now - times[v]) >= duration));
      end
   end

   // stale index wraps modulo the pool size by repeated subtraction
   always_comb begin
      n_ext = MOD_W'(n);
      rem   = MOD_W'(next_raw);
      for (int k = 0; k < MOD_STEPS; k++) begin
         if ((n_ext != '0) && (rem >= n_ext)) begin
            rem = rem - n_ext;
         end
      end
      start_in = VIDX_W'(rem);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         free_ff  <= free_in;
         start_ff <= start_in;
      end
   end

   // rotating priority: first free at or after start, else first free overall
   always_comb begin
      pick_upper = '0;
      pick_any   = '0;
      for (int v = 0; v < MAX_VOICES; v++) begin
         upper[v] = free_ff[v] && (VIDX_W'(v) >= start_ff);
      end
      for (int v = MAX_VOICES - 1; v >= 0; v--) begin
         if (upper[v]) begin
            pick_upper = VIDX_W'(v);
         end
         if (free_ff[v]) begin
            pick_any = VIDX_W'(v);
         end
      end
      found = |free_ff;
      pick  = (|upper) ? pick_upper : pick_any;
   end

endmodule

`default_nettype wire

// ===== hdl/round_robin_voice_allocator.sv =====
// result path: a request passes the voice memory read register, the scan register
//   and the output register; rsp_stall holds the previous result in the output register
// requests: req_stall stays high from a transfer until the read, scan and write-back
//   of the sound's row in the voice memory (one row read and one row written) are done
// reset: synchronous; configuration returns to its defaults, then a clearing pass
//   zeroes every row of the voice memory while req_stall stays high
`default_nettype none

module round_robin_voice_allocator
   import rrva_pkg::*;
#(
   parameter int NUM_SOUNDS = 32,
   parameter int MAX_VOICES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
   localparam int CNT_W  = $clog2(MAX_VOICES + 1);
   localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_PICK  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [MASK_W-1:0]  pooled_mask_ff;
   logic [POOL_W-1:0]  pool_voices_ff;
   logic [STAMP_W-1:0] duration_ff;

   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic [STAMP_W-1:0] now_ff;
   logic [CNT_W-1:0]   n_ff;
   logic               pooled_ff;
   logic               direct_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [CNT_W-1:0]   n_eff;
   logic               in_range;
   logic               mask_bit;

   logic [MAX_VOICES-1:0][STAMP_W-1:0] rd_times;
   logic [NEXT_W-1:0]  rd_next;
   wr_type             wr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [MAX_VOICES-1:0] wr_lanes;
   logic [MAX_VOICES-1:0] pick_lanes;

   logic               found;
   logic [VIDX_W-1:0]  pick;
   logic [CNT_W-1:0]   pick_inc;
   logic [CNT_W-1:0]   next_new;
   logic               slot_free;
   logic               take;
   logic               grant;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pooled_mask_ff <= '0;
         pool_voices_ff <= POOL_VOICES_RESET;
         duration_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POOLED_MASK: pooled_mask_ff <= csr_data;
            CSR_POOL_VOICES: pool_voices_ff <= csr_data[POOL_W-1:0];
            CSR_DURATION:    duration_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // request classification at transfer
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign in_range  = int'(req_data.sound_id) < NUM_SOUNDS;
   assign mask_bit  = pooled_mask_ff[req_data.sound_id];

   always_comb begin
      if (int'(pool_voices_ff) > MAX_VOICES) begin
         n_eff = CNT_W'(MAX_VOICES);
      end else begin
         n_eff = CNT_W'(pool_voices_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= ADDR_W'(req_data.sound_id);
         now_ff    <= req_data.now_ms;
         n_ff      <= n_eff;
         pooled_ff <= in_range && mask_bit && (n_eff != '0);
         direct_ff <= in_range && !(mask_bit && (n_eff != '0));
      end
   end

   // voice memory and scan unit
   rrva_voice_mem #(
      .NUM_SOUNDS (NUM_SOUNDS),
      .MAX_VOICES (MAX_VOICES)
   ) u_mem (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (ADDR_W'(req_data.sound_id)),
      .rd_times (rd_times),
      .rd_next  (rd_next),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .wr_lanes (wr_lanes)
   );

   rrva_scan #(
      .MAX_VOICES (MAX_VOICES)
   ) u_scan (
      .clock    (clock),
      .load     (state_ff == S_READ),
      .times    (rd_times),
      .next_raw (rd_next),
      .now      (now_ff),
      .duration (duration_ff),
      .n        (n_ff),
      .found    (found),
      .pick     (pick)
   );

   // result and write-back in the pick cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign take      = (state_ff == S_PICK) && slot_free;
   assign grant     = pooled_ff && found;
   assign pick_inc  = CNT_W'(pick) + CNT_W'(1);
   assign next_new  = (pick_inc == n_ff) ? '0 : pick_inc;

   always_comb begin
      for (int v = 0; v < MAX_VOICES; v++) begin
         pick_lanes[v] = (pick == VIDX_W'(v));
      end
   end

   // write port: clearing pass or granted voice
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr.en      = 1'b1;
         wr.next_we = 1'b1;
         wr.next    = '0;
         wr.stamp   = '0;
         wr_addr    = clr_ff;
         wr_lanes   = '1;
      end else begin
         wr.en      = take && grant;
         wr.next_we = 1'b1;
         wr.next    = NEXT_W'(next_new);
         wr.stamp   = now_ff;
         wr_addr    = addr_ff;
         wr_lanes   = pick_lanes;
      end
   end

   always_comb begin
      rsp_in.direct_play   = direct_ff;
      rsp_in.voice_granted = grant;
      rsp_in.voice_number  = grant ? VNUM_W'(pick) : '0;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NUM_SOUNDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_read_then_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_PICK))
      else $error("read stage not followed by pick");

   a_grant_write: assert property (@(posedge clock) disable iff (reset)
      (wr.en && (state_ff != S_CLEAR)) |-> ($onehot(wr_lanes) && pooled_ff && found))
      else $error("voice write without a single granted voice");

   a_grant_result: assert property (@(posedge clock) disable iff (reset)
      (take && grant) |=> (rsp_valid_ff && rsp_ff.voice_granted && !rsp_ff.direct_play))
      else $error("granted voice not reported");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && ($past(state_ff) == S_CLEAR))
         |-> ($past(clr_ff) == ADDR_W'(NUM_SOUNDS - 1)))
      else $error("clearing pass ended early");

endmodule

`default_nettype wire

// ===== tb/tb_round_robin_voice_allocator.sv =====
`default_nettype none

module tb_round_robin_voice_allocator;
   import rrva_pkg::*;

   localparam int N_SOUNDS     = 32;
   localparam int N_VOICES     = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 10;
   localparam int CHUNKS       = 13;
   localparam int CHUNK_ITEMS  = 50;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_POOLED_MASK;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   // own copy of the allocator state and settings
   logic [STAMP_W-1:0] voice_stamp [N_SOUNDS][N_VOICES];
   logic [NEXT_W-1:0]  next_slot [N_SOUNDS];
   logic [MASK_W-1:0]  mask_cfg  = '0;
   logic [POOL_W-1:0]  pool_cfg  = POOL_VOICES_RESET;
   logic [STAMP_W-1:0] dur_cfg   = '0;

   rsp_type pending_outcomes [$];

   int errors        = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;
   int hold_left     = 0;
   logic hold_go     = 1'b0;
   int n_direct      = 0;
   int n_granted     = 0;
   int n_busy        = 0;
   int n_writes      = 0;

   round_robin_voice_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // outcome of one trigger, updating the voice state as the block does
   function automatic rsp_type allocate_voice(input logic [SID_W-1:0] sid,
                                              input logic [STAMP_W-1:0] now);
      rsp_type            res;
      int                 n;
      int                 first;
      int                 v;
      logic [STAMP_W-1:0] t;
      logic [STAMP_W-1:0] elapsed;
      res = '0;
      n = (int'(pool_cfg) > N_VOICES) ? N_VOICES : int'(pool_cfg);
      if (!mask_cfg[sid] || n == 0) begin
         res.direct_play = 1'b1;
         return res;
      end
      // a saved index past a shrunken pool wraps round
      first = int'(next_slot[sid]) % n;
      for (int i = 0; i < n; i++) begin
         v = (first + i) % n;
         t = voice_stamp[sid][v];
         elapsed = now - t;
         if (t == '0 || elapsed >= dur_cfg) begin
            voice_stamp[sid][v] = now;
            next_slot[sid] = NEXT_W'((v + 1) % n);
            res.voice_granted = 1'b1;
            res.voice_number = VNUM_W'(v);
            return res;
         end
      end
      return res;
   endfunction

   // one trigger transfer, with random idle cycles ahead of it
   task automatic send_trigger(input logic [SID_W-1:0] sid, input logic [STAMP_W-1:0] now);
      rsp_type outcome;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{sound_id: sid, now_ms: now};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      outcome = allocate_voice(sid, now);
      pending_outcomes.insert(pending_outcomes.size(), outcome);
   endtask

   // drop valid and wait for every outstanding result
   task automatic finish_burst();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all three registers back to back while idle
   task automatic set_config(input logic [MASK_W-1:0] mask, input logic [POOL_W-1:0] voices,
                             input logic [STAMP_W-1:0] dur);
      logic [CSR_DATA_W-1:0] value [3];
      logic [CSR_IDX_W-1:0]  index [3];
      index[0] = CSR_POOLED_MASK;
      index[1] = CSR_POOL_VOICES;
      index[2] = CSR_DURATION;
      value[0] = mask;
      value[1] = CSR_DATA_W'(voices);
      value[2] = dur;
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index[i];
         csr_data <= value[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         n_writes++;
      end
      csr_valid <= 1'b0;
      mask_cfg = mask;
      pool_cfg = voices;
      dur_cfg = dur;
   endtask

   // reset values: nothing is pooled
   task automatic test_unpooled_defaults();
      send_trigger(5'd0, 32'd0);
      send_trigger(5'd31, 32'hFFFF_FFFF);
      send_trigger(5'd10, $urandom);
      finish_burst();
   endtask

   // round-robin order, all voices busy, freed exactly at the duration
   task automatic test_round_robin();
      set_config('1, 4'd3, 32'd100);
      repeat (4) send_trigger(5'd5, 32'd1000);
      send_trigger(5'd5, 32'd1099);
      send_trigger(5'd5, 32'd1100);
      finish_burst();
   endtask

   // start at time zero and elapsed time across the wrap
   task automatic test_time_edges();
      set_config(32'h8000_0001, 4'd2, 32'd50);
      send_trigger(5'd31, 32'd0);
      send_trigger(5'd31, 32'd0);
      send_trigger(5'd0, 32'hFFFF_FFF0);
      send_trigger(5'd0, 32'h0000_0010);
      send_trigger(5'd0, 32'h0000_0020);
      send_trigger(5'd0, 32'h0000_0022);
      send_trigger(5'd1, 32'h0000_0022);
      finish_burst();
   endtask

   // zero duration frees at once, full-scale duration never frees
   task automatic test_duration_extremes();
      set_config('1, 4'd2, 32'd0);
      send_trigger(5'd7, 32'd123);
      send_trigger(5'd7, 32'd123);
      send_trigger(5'd7, 32'd123);
      finish_burst();
      set_config('1, 4'd2, 32'hFFFF_FFFF);
      send_trigger(5'd8, 32'd1);
      send_trigger(5'd8, 32'd2);
      send_trigger(5'd8, 32'd3);
      finish_burst();
   endtask

   // oversized, shrunken (stale index), empty and single-voice pools
   task automatic test_pool_sizes();
      set_config('1, 4'd15, 32'd10);
      repeat (3) send_trigger(5'd3, 32'd100);
      finish_burst();
      set_config('1, 4'd2, 32'd10);
      send_trigger(5'd3, 32'd200);
      finish_burst();
      set_config('1, 4'd0, 32'd10);
      send_trigger(5'd3, 32'd300);
      finish_burst();
      set_config('1, 4'd1, 32'd10);
      send_trigger(5'd3, 32'd400);
      send_trigger(5'd3, 32'd405);
      send_trigger(5'd3, 32'd410);
      finish_burst();
   endtask

   // long receiver hold while the sender keeps offering
   task automatic test_back_pressure();
      logic [STAMP_W-1:0] clk_ms;
      int                 saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      clk_ms = 32'd5000;
      set_config('1, 4'd8, 32'd20);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      repeat (24) begin
         clk_ms = clk_ms + $urandom_range(10);
         send_trigger(SID_W'($urandom_range(3)), clk_ms);
      end
      finish_burst();
      send_idle_pct = saved_pct;
   endtask

   // random settings, mostly advancing time on a few hot sounds
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      logic [MASK_W-1:0]  mask;
      logic [POOL_W-1:0]  voices;
      logic [STAMP_W-1:0] dur;
      logic [STAMP_W-1:0] clk_ms;
      logic [STAMP_W-1:0] span;
      logic [STAMP_W-1:0] now;
      logic [SID_W-1:0]   sid;
      int                 hot;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int c = 0; c < CHUNKS; c++) begin
         case ($urandom_range(7))
            0, 1, 2, 3: mask = '1;
            4:          mask = $urandom;
            5:          mask = '0;
            default:    mask = $urandom | 32'h0000_000F;
         endcase
         voices = ($urandom_range(9) < 8) ? POOL_W'($urandom_range(1, 8))
                                          : POOL_W'($urandom_range(15));
         case ($urandom_range(7))
            0:       dur = '0;
            1:       dur = '1;
            2:       dur = $urandom;
            default: dur = $urandom_range(1, 400);
         endcase
         case ($urandom_range(3))
            0:       clk_ms = $urandom;
            1:       clk_ms = 32'hFFFF_FFFF - $urandom_range(500);
            default: clk_ms = $urandom_range(1, 1000);
         endcase
         set_config(mask, voices, dur);
         hot = $urandom_range(N_SOUNDS - 4);
         span = (dur == '0 || dur > 32'd2000) ? 32'd200 : dur;
         for (int i = 0; i < CHUNK_ITEMS; i++) begin
            sid = ($urandom_range(3) != 0) ? SID_W'(hot + $urandom_range(3))
                                           : SID_W'($urandom_range(N_SOUNDS - 1));
            clk_ms = clk_ms + $urandom_range(0, span / 2);
            case ($urandom_range(19))
               0:       now = '0;
               1:       now = $urandom;
               default: now = clk_ms;
            endcase
            send_trigger(sid, now);
         end
         finish_burst();
      end
   endtask

   // receiver stall: random, or a long counted hold on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_go) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result transfer with nothing expected: %p", rsp_data);
            errors++;
         end else begin
            want = pending_outcomes.pop_front();
            if (want.direct_play) n_direct++;
            else if (want.voice_granted) n_granted++;
            else n_busy++;
            if (rsp_data.direct_play !== want.direct_play) begin
               $error("direct_play: expected %0d, got %0d", want.direct_play,
                      rsp_data.direct_play);
               errors++;
            end
            if (rsp_data.voice_granted !== want.voice_granted) begin
               $error("voice_granted: expected %0d, got %0d", want.voice_granted,
                      rsp_data.voice_granted);
               errors++;
            end
            if (rsp_data.voice_number !== want.voice_number) begin
               $error("voice_number: expected %0d, got %0d", want.voice_number,
                      rsp_data.voice_number);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transfer for %0d cycles", QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int s = 0; s < N_SOUNDS; s++) begin
         next_slot[s] = '0;
         for (int v = 0; v < N_VOICES; v++) voice_stamp[s][v] = '0;
      end
      send_idle_pct = 26;
      recv_idle_pct = 81;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_unpooled_defaults();
      test_round_robin();
      test_time_edges();
      test_duration_extremes();
      test_pool_sizes();
      test_back_pressure();
      test_random_traffic(26, 81);
      test_random_traffic(81, 26);
      test_random_traffic(0, 0);

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d triggers: %0d direct plays, %0d voices granted, %0d all busy",
               n_direct + n_granted + n_busy, n_direct, n_granted, n_busy);
      $display("%0d register writes, three idling patterns and one long receiver hold",
               n_writes);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
